@@ rtl/wthb_pkg.sv @@
// Package for the Wang-tile heat-bath update block.
// Holds field widths, codes, the controller state type and the command and
// status structs shared by the controller, the datapath and the top level.
`default_nettype none

package wthb_pkg;

   // Fixed field widths.
   localparam int TILE_BITS   = 6;
   localparam int COUNT_BITS  = 7;
   localparam int WEIGHT_BITS = 25;
   localparam int RAND_BITS   = 32;
   localparam int SUM_BITS    = 32;
   localparam int PROD_BITS   = RAND_BITS + SUM_BITS;
   localparam int ENERGY_BITS = 3;
   localparam int CSR_BITS    = 3;
   localparam int SIDES       = 4;
   localparam int WEIGHTS     = 5;

   // Largest energy excess that selects its own weight.
   localparam logic [ENERGY_BITS-1:0] EXCESS_MAX = 3'd4;

   // Request mode codes.
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_UPDATE = 1'b1;

   // Lock mode codes.
   localparam logic [1:0] LOCK_FREE     = 2'd0;
   localparam logic [1:0] LOCK_BOUNDARY = 2'd1;
   localparam logic [1:0] LOCK_PINNED   = 2'd2;
   localparam logic [1:0] LOCK_SPARE    = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_BITS-1:0] CSR_TILE_COUNT = 3'd0;
   localparam logic [CSR_BITS-1:0] CSR_WEIGHT_0   = 3'd1;
   localparam logic [CSR_BITS-1:0] CSR_WEIGHT_1   = 3'd2;
   localparam logic [CSR_BITS-1:0] CSR_WEIGHT_2   = 3'd3;
   localparam logic [CSR_BITS-1:0] CSR_WEIGHT_3   = 3'd4;
   localparam logic [CSR_BITS-1:0] CSR_WEIGHT_4   = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [COUNT_BITS-1:0]  TILE_COUNT_RESET = 7'd1;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_0_RESET   = 25'd16777216;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_N_RESET   = 25'd1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CUR_RD,
      ST_CUR_LATCH,
      ST_ENERGY,
      ST_WSUM,
      ST_MUL,
      ST_PICK,
      ST_DONE
   } wthb_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;        // latch an update request
      logic load;         // write a tile table entry
      logic rd_cur;       // read the current tile's entry
      logic latch_cur;    // capture the current entry, set min to EXCESS_MAX, clear sum
      logic pass_energy;  // scan: minimum energy over allowed tiles
      logic pass_wsum;    // scan: weight sum
      logic mul;          // scale the random word by the weight sum
      logic pass_pick;    // scan: roulette selection
      logic emit;         // load the result register
   } wthb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;    // current scan has issued and processed all tiles
      logic sum_zero;     // weight sum is zero
      logic out_free;     // result register can take a new result
   } wthb_status_type;

endpackage

`default_nettype wire

@@ rtl/wthb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; used for the tile table.
`default_nettype none

module wthb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/wthb_ctrl.sv @@
// Controller state machine for the Wang-tile heat-bath update.
// Depends on wthb_pkg; drives the datapath through wthb_cmd_type.
`default_nettype none

module wthb_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_mode,
   input  wire logic [1:0]                req_lock_mode,
   input  wire wthb_pkg::wthb_status_type status,
   output wthb_pkg::wthb_cmd_type         cmd
);

   import wthb_pkg::*;

   wthb_state_type state_ff;
   wthb_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  if (req_lock_mode inside {LOCK_PINNED, LOCK_SPARE}) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_CUR_RD;
                  end
               end
            end
         end
         ST_CUR_RD: begin
            cmd.rd_cur = 1'b1;
            state_in   = ST_CUR_LATCH;
         end
         ST_CUR_LATCH: begin
            cmd.latch_cur = 1'b1;
            state_in      = ST_ENERGY;
         end
         ST_ENERGY: begin
            cmd.pass_energy = 1'b1;
            if (status.scan_done) begin
               state_in = ST_WSUM;
            end
         end
         ST_WSUM: begin
            cmd.pass_wsum = 1'b1;
            if (status.scan_done) begin
               state_in = status.sum_zero ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.pass_pick = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/wthb_dp.sv @@
// Datapath for the Wang-tile heat-bath update: tile table, configuration
// registers, scan counter, energy and weight logic, multiplier, result register.
// Depends on wthb_pkg and wthb_ram; commanded by wthb_ctrl.
`default_nettype none

module wthb_dp #(
   parameter int TILE_SLOTS = 64,
   parameter int COLOR_BITS = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire wthb_pkg::wthb_cmd_type    cmd,
   output wthb_pkg::wthb_status_type      status,
   input  wire logic [5:0]                req_tile_index,
   input  wire logic [COLOR_BITS-1:0]     req_color_top,
   input  wire logic [COLOR_BITS-1:0]     req_color_bottom,
   input  wire logic [COLOR_BITS-1:0]     req_color_left,
   input  wire logic [COLOR_BITS-1:0]     req_color_right,
   input  wire logic [3:0]                req_edge_mask,
   input  wire logic [1:0]                req_lock_mode,
   input  wire logic [31:0]               req_random_word,
   input  wire logic                      csr_write_enable,
   input  wire logic [2:0]                csr_index,
   input  wire logic [24:0]               csr_write_data,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   output logic [5:0]                     rsp_new_tile,
   output logic                           rsp_kept
);

   import wthb_pkg::*;

   localparam int AW = (TILE_SLOTS > 1) ? $clog2(TILE_SLOTS) : 1;
   localparam int KW = AW + 1;
   localparam int EW = SIDES * COLOR_BITS;

   // Latched request fields.
   logic [TILE_BITS-1:0]               cur_ff, cur_in;
   logic [SIDES-1:0][COLOR_BITS-1:0]   nb_ff, nb_in;
   logic [SIDES-1:0]                   mask_ff, mask_in;
   logic                               lock_bnd_ff, lock_bnd_in;
   logic [RAND_BITS-1:0]               rnd_ff, rnd_in;
   logic [EW-1:0]                      cur_entry_ff, cur_entry_in;

   // Scan and accumulation state.
   logic [KW-1:0]                      cnt_ff, cnt_in;
   logic                               proc_ff, proc_in;
   logic [KW-1:0]                      tidx_ff, tidx_in;
   logic [ENERGY_BITS-1:0]             min_ff, min_in;
   logic [SUM_BITS-1:0]                sum_ff, sum_in;
   logic [PROD_BITS-1:0]               prod_ff, prod_in;
   logic [SUM_BITS-1:0]                acc_ff, acc_in;
   logic                               found_ff, found_in;
   logic [TILE_BITS-1:0]               pick_ff, pick_in;

   // Configuration registers.
   logic [COUNT_BITS-1:0]              tile_count_ff, tile_count_in;
   logic [WEIGHT_BITS-1:0]             weight_ff [WEIGHTS];
   logic [WEIGHT_BITS-1:0]             weight_in [WEIGHTS];

   // Result register.
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [TILE_BITS-1:0]               new_tile_ff, new_tile_in;
   logic                               kept_ff, kept_in;

   // Combinational signals.
   logic [KW-1:0]                      n;
   logic                               scan;
   logic                               issue;
   logic                               scan_done;
   logic                               cur_valid;
   logic                               wr_en;
   logic [AW-1:0]                      rd_addr;
   logic [EW-1:0]                      rd_data;
   logic [EW-1:0]                      wr_data;
   logic [SIDES-1:0]                   mism;
   logic [SIDES-1:0]                   barred;
   logic                               allowed;
   logic [ENERGY_BITS-1:0]             energy;
   logic [ENERGY_BITS-1:0]             excess;
   logic [WEIGHT_BITS-1:0]             weight_sel;
   logic [SUM_BITS-1:0]                scaled;

   // Candidate count is the tile count limited to the table size.
   always_comb begin
      if (32'(tile_count_ff) > TILE_SLOTS) begin
         n = KW'(TILE_SLOTS);
      end else begin
         n = KW'(tile_count_ff);
      end
   end

   // Scan sequencing: issue one read a cycle, process its data in the next cycle.
   assign scan      = cmd.pass_energy | cmd.pass_wsum | cmd.pass_pick;
   assign issue     = scan && (cnt_ff < n);
   assign scan_done = scan && !issue && !proc_ff;

   // Tile table.
   assign cur_valid = 32'(cur_ff) < TILE_SLOTS;
   assign wr_en     = cmd.load && (32'(req_tile_index) < TILE_SLOTS);
   assign wr_data   = {req_color_right, req_color_left, req_color_bottom, req_color_top};
   assign rd_addr   = cmd.rd_cur ? AW'(cur_ff) : cnt_ff[AW-1:0];

   wthb_ram #(
      .WIDTH (EW),
      .DEPTH (TILE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_tile_index)),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_cur | issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Edge mismatches and boundary lock for the entry just read.
   always_comb begin
      logic [COLOR_BITS-1:0] col;
      logic [COLOR_BITS-1:0] col_cur;
      for (int s = 0; s < SIDES; s++) begin
         col       = rd_data[s*COLOR_BITS +: COLOR_BITS];
         col_cur   = cur_entry_ff[s*COLOR_BITS +: COLOR_BITS];
         mism[s]   = mask_ff[s] && (col != nb_ff[s]);
         barred[s] = lock_bnd_ff && !mask_ff[s] && (col != col_cur);
      end
      allowed = ~|barred;
      energy  = {2'b00, mism[0]} + {2'b00, mism[1]} + {2'b00, mism[2]} + {2'b00, mism[3]};
   end

   // Weight for the energy excess over the minimum; for an allowed tile the excess never passes four.
   assign excess = energy - min_ff;
   always_comb begin
      case (excess)
         3'd0:    weight_sel = weight_ff[0];
         3'd1:    weight_sel = weight_ff[1];
         3'd2:    weight_sel = weight_ff[2];
         3'd3:    weight_sel = weight_ff[3];
         default: weight_sel = weight_ff[4];
      endcase
   end

   assign scaled = prod_ff[PROD_BITS-1:SUM_BITS];

   // Next-state logic of the datapath registers.
   always_comb begin
      cur_in        = cur_ff;
      nb_in         = nb_ff;
      mask_in       = mask_ff;
      lock_bnd_in   = lock_bnd_ff;
      rnd_in        = rnd_ff;
      cur_entry_in  = cur_entry_ff;
      min_in        = min_ff;
      sum_in        = sum_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      tile_count_in = tile_count_ff;
      weight_in     = weight_ff;
      rsp_valid_in  = rsp_valid_ff;
      new_tile_in   = new_tile_ff;
      kept_in       = kept_ff;

      // Capture an update request; the current tile is the default result.
      if (cmd.start) begin
         cur_in      = req_tile_index;
         nb_in       = {req_color_right, req_color_left, req_color_bottom, req_color_top};
         mask_in     = req_edge_mask;
         lock_bnd_in = (req_lock_mode == LOCK_BOUNDARY);
         rnd_in      = req_random_word;
         pick_in     = req_tile_index;
         found_in    = 1'b0;
      end

      // An out-of-range current tile reads as all colors zero.
      if (cmd.latch_cur) begin
         cur_entry_in = cur_valid ? rd_data : '0;
         min_in       = EXCESS_MAX;
         sum_in       = '0;
      end

      // Scan counter.
      proc_in = issue;
      tidx_in = cnt_ff;
      if (scan_done) begin
         cnt_in = '0;
      end else if (issue) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end

      // First pass: minimum energy over allowed tiles.
      if (proc_ff && cmd.pass_energy && allowed && (energy < min_ff)) begin
         min_in = energy;
      end

      // Second pass: weight sum.
      if (proc_ff && cmd.pass_wsum && allowed) begin
         sum_in = sum_ff + SUM_BITS'(weight_sel);
      end

      // Scale the random word by the sum.
      if (cmd.mul) begin
         prod_in = PROD_BITS'(rnd_ff) * PROD_BITS'(sum_ff);
         acc_in  = '0;
      end

      // Third pass: first tile whose running total passes the scaled draw.
      if (proc_ff && cmd.pass_pick && allowed && (weight_sel != '0) && !found_ff) begin
         acc_in = acc_ff + SUM_BITS'(weight_sel);
         if (scaled < acc_in) begin
            found_in = 1'b1;
            pick_in  = TILE_BITS'(tidx_ff);
         end
      end

      // Result register.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         new_tile_in  = pick_ff;
         kept_in      = !found_ff;
      end

      // Configuration writes; indexes beyond the list are ignored.
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TILE_COUNT: tile_count_in = csr_write_data[COUNT_BITS-1:0];
            CSR_WEIGHT_0:   weight_in[0]  = csr_write_data;
            CSR_WEIGHT_1:   weight_in[1]  = csr_write_data;
            CSR_WEIGHT_2:   weight_in[2]  = csr_write_data;
            CSR_WEIGHT_3:   weight_in[3]  = csr_write_data;
            CSR_WEIGHT_4:   weight_in[4]  = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         proc_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tile_count_ff <= TILE_COUNT_RESET;
         weight_ff[0]  <= WEIGHT_0_RESET;
         weight_ff[1]  <= WEIGHT_N_RESET;
         weight_ff[2]  <= WEIGHT_N_RESET;
         weight_ff[3]  <= WEIGHT_N_RESET;
         weight_ff[4]  <= WEIGHT_N_RESET;
      end else begin
         cnt_ff        <= cnt_in;
         proc_ff       <= proc_in;
         rsp_valid_ff  <= rsp_valid_in;
         tile_count_ff <= tile_count_in;
         weight_ff     <= weight_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      nb_ff        <= nb_in;
      mask_ff      <= mask_in;
      lock_bnd_ff  <= lock_bnd_in;
      rnd_ff       <= rnd_in;
      cur_entry_ff <= cur_entry_in;
      tidx_ff      <= tidx_in;
      min_ff       <= min_in;
      sum_ff       <= sum_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      found_ff     <= found_in;
      pick_ff      <= pick_in;
      new_tile_ff  <= new_tile_in;
      kept_ff      <= kept_in;
   end

   // Status and result ports.
   assign status.scan_done = scan_done;
   assign status.sum_zero  = (sum_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_new_tile = new_tile_ff;
   assign rsp_kept     = kept_ff;

endmodule

`default_nettype wire

@@ rtl/wang_tile_heat_bath_fixed.sv @@
// Top level of the Wang-tile heat-bath update block.
// Depends on wthb_pkg, wthb_ctrl and wthb_dp (which holds wthb_ram).
//
//   Channel   Ports                         Moves
//   req       req_valid / req_ready         one request: table load or cell update
//   rsp       rsp_valid / rsp_ready         new tile and kept flag, one per update
//   csr       csr_write_enable              one register write, no wait
//
// A load request is written into the tile table as it is accepted. An update holds
// off the next request until it returns to idle. The single read port of the tile
// table is swept three times over n tiles, where n is the tile count limited to
// TILE_SLOTS (minimum energy, weight sum, roulette pick). An update whose weight sum
// is zero stops after the second sweep. A pinned or spare cell goes straight to the
// result. Reset is synchronous and active high; the tile table has no reset. A
// stalled result holds in the result register while the next request is accepted
// and worked on; that request waits in its last state until the result register
// is free.
`default_nettype none

module wang_tile_heat_bath_fixed #(
   parameter int TILE_SLOTS = 64,
   parameter int COLOR_BITS = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_mode,
   input  wire logic [5:0]            req_tile_index,
   input  wire logic [COLOR_BITS-1:0] req_color_top,
   input  wire logic [COLOR_BITS-1:0] req_color_bottom,
   input  wire logic [COLOR_BITS-1:0] req_color_left,
   input  wire logic [COLOR_BITS-1:0] req_color_right,
   input  wire logic [3:0]            req_edge_mask,
   input  wire logic [1:0]            req_lock_mode,
   input  wire logic [31:0]           req_random_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [5:0]                 rsp_new_tile,
   output logic                       rsp_kept,
   input  wire logic                  csr_write_enable,
   input  wire logic [2:0]            csr_index,
   input  wire logic [24:0]           csr_write_data
);

   import wthb_pkg::*;

   wthb_cmd_type    cmd;
   wthb_status_type status;

   // Controller.
   wthb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_lock_mode (req_lock_mode),
      .status        (status),
      .cmd           (cmd)
   );

   // Datapath.
   wthb_dp #(
      .TILE_SLOTS (TILE_SLOTS),
      .COLOR_BITS (COLOR_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_tile_index   (req_tile_index),
      .req_color_top    (req_color_top),
      .req_color_bottom (req_color_bottom),
      .req_color_left   (req_color_left),
      .req_color_right  (req_color_right),
      .req_edge_mask    (req_edge_mask),
      .req_lock_mode    (req_lock_mode),
      .req_random_word  (req_random_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_new_tile     (rsp_new_tile),
      .rsp_kept         (rsp_kept)
   );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for the Wang-tile heat-bath update block.
// Uses wthb_pkg for codes and widths and drives wang_tile_heat_bath_fixed.
// Results are checked against a tile predictor kept inside this module.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wthb_pkg::*;

   localparam int TILE_SLOTS     = 64;
   localparam int COLOR_BITS     = 4;
   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 7;
   localparam int DRAIN_CYCLES   = 3 * TILE_SLOTS + 16;
   localparam int PHASES         = 8;
   localparam int PHASE_REQUESTS = 125;
   localparam int HOLD_AT_RESULT = 120;
   localparam int HOLD_CYCLES    = 3000;
   localparam int LIMIT_CYCLES   = 1_000_000;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_FULL = '1;

   typedef struct packed {
      logic                  mode;
      logic [TILE_BITS-1:0]  tile_index;
      logic [COLOR_BITS-1:0] color_top;
      logic [COLOR_BITS-1:0] color_bottom;
      logic [COLOR_BITS-1:0] color_left;
      logic [COLOR_BITS-1:0] color_right;
      logic [SIDES-1:0]      edge_mask;
      logic [1:0]            lock_mode;
      logic [RAND_BITS-1:0]  random_word;
   } tile_request_type;

   typedef struct packed {
      logic [TILE_BITS-1:0] new_tile;
      logic                 kept;
   } tile_result_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]                tile_count;
      logic [WEIGHTS-1:0][WEIGHT_BITS-1:0] weight;
   } tile_config_type;

   typedef struct packed {
      logic             is_config;
      tile_config_type  cfg;
      tile_request_type rq;
      logic             typed;
      tile_result_type  want;
   } stimulus_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = MODE_LOAD;
   logic [TILE_BITS-1:0] req_tile_index = '0;
   logic [COLOR_BITS-1:0] req_color_top = '0;
   logic [COLOR_BITS-1:0] req_color_bottom = '0;
   logic [COLOR_BITS-1:0] req_color_left = '0;
   logic [COLOR_BITS-1:0] req_color_right = '0;
   logic [SIDES-1:0] req_edge_mask = '0;
   logic [1:0] req_lock_mode = LOCK_FREE;
   logic [RAND_BITS-1:0] req_random_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [TILE_BITS-1:0] rsp_new_tile;
   logic rsp_kept;
   logic csr_write_enable = 1'b0;
   logic [CSR_BITS-1:0] csr_index = CSR_TILE_COUNT;
   logic [WEIGHT_BITS-1:0] csr_write_data = '0;

   // Shadow copies of the tile table and the registers.
   logic [SIDES*COLOR_BITS-1:0] tile_colors [TILE_SLOTS];
   tile_config_type live_config;

   tile_result_type  expected_tiles [$];
   stimulus_row_type directed_rows [$];
   int unsigned      fail_count = 0;
   int unsigned      results_taken = 0;
   int unsigned      cycle_count = 0;
   bit               send_quiet = 1'b0;
   bit               take_quiet = 1'b0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   wang_tile_heat_bath_fixed #(
      .TILE_SLOTS(TILE_SLOTS),
      .COLOR_BITS(COLOR_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_tile_index(req_tile_index),
      .req_color_top(req_color_top),
      .req_color_bottom(req_color_bottom),
      .req_color_left(req_color_left),
      .req_color_right(req_color_right),
      .req_edge_mask(req_edge_mask),
      .req_lock_mode(req_lock_mode),
      .req_random_word(req_random_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_new_tile(rsp_new_tile),
      .rsp_kept(rsp_kept),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Heat-bath choice for one update: energies, minimum, weight sum, roulette.
   function automatic tile_result_type predict_update(input tile_request_type rq);
      tile_result_type res;
      logic [SIDES*COLOR_BITS-1:0] cur_entry;
      logic [SIDES*COLOR_BITS-1:0] entry;
      logic [SIDES*COLOR_BITS-1:0] facing;
      int unsigned energy [TILE_SLOTS];
      bit allowed [TILE_SLOTS];
      logic [63:0] weight_of [TILE_SLOTS];
      logic [63:0] sum;
      logic [63:0] acc;
      logic [63:0] scaled;
      int unsigned n;
      int unsigned min_e;
      int unsigned cnt;
      int unsigned ex;
      bit present;
      res.new_tile = rq.tile_index;
      res.kept = 1'b1;
      if (rq.lock_mode == LOCK_PINNED || rq.lock_mode == LOCK_SPARE) begin
         return res;
      end
      cur_entry = tile_colors[rq.tile_index];
      facing = {rq.color_right, rq.color_left, rq.color_bottom, rq.color_top};
      n = (live_config.tile_count < TILE_SLOTS) ? live_config.tile_count : TILE_SLOTS;
      min_e = int'(EXCESS_MAX);
      for (int t = 0; t < n; t++) begin
         entry = tile_colors[t];
         cnt = 0;
         allowed[t] = 1'b1;
         for (int s = 0; s < SIDES; s++) begin
            present = rq.edge_mask[s];
            if (rq.lock_mode == LOCK_BOUNDARY && !present &&
                entry[s*COLOR_BITS +: COLOR_BITS] != cur_entry[s*COLOR_BITS +: COLOR_BITS]) begin
               allowed[t] = 1'b0;
            end
            if (present && entry[s*COLOR_BITS +: COLOR_BITS] !=
                facing[s*COLOR_BITS +: COLOR_BITS]) begin
               cnt++;
            end
         end
         energy[t] = cnt;
         if (allowed[t] && cnt < min_e) begin
            min_e = cnt;
         end
      end
      sum = '0;
      for (int t = 0; t < n; t++) begin
         weight_of[t] = '0;
         if (allowed[t]) begin
            ex = energy[t] - min_e;
            if (ex > int'(EXCESS_MAX)) begin
               ex = int'(EXCESS_MAX);
            end
            weight_of[t] = 64'(live_config.weight[ex]);
            sum += weight_of[t];
         end
      end
      // No weight at all leaves the cell as it is.
      if (sum == 0) begin
         return res;
      end
      scaled = (64'(rq.random_word) * sum) >> 32;
      acc = '0;
      res.kept = 1'b0;
      for (int t = 0; t < n; t++) begin
         if (weight_of[t] != 0) begin
            acc += weight_of[t];
            if (scaled < acc) begin
               res.new_tile = TILE_BITS'(t);
               break;
            end
         end
      end
      return res;
   endfunction

   function automatic tile_request_type make_request(
      input logic mode, input int unsigned idx,
      input int unsigned top, input int unsigned bottom,
      input int unsigned left, input int unsigned right,
      input int unsigned mask, input logic [1:0] lock, input logic [31:0] rnd
   );
      tile_request_type rq;
      rq.mode = mode;
      rq.tile_index = TILE_BITS'(idx);
      rq.color_top = COLOR_BITS'(top);
      rq.color_bottom = COLOR_BITS'(bottom);
      rq.color_left = COLOR_BITS'(left);
      rq.color_right = COLOR_BITS'(right);
      rq.edge_mask = SIDES'(mask);
      rq.lock_mode = lock;
      rq.random_word = rnd;
      return rq;
   endfunction

   function automatic tile_config_type make_config(
      input int unsigned count, input logic [WEIGHT_BITS-1:0] w0,
      input logic [WEIGHT_BITS-1:0] w1, input logic [WEIGHT_BITS-1:0] w2,
      input logic [WEIGHT_BITS-1:0] w3, input logic [WEIGHT_BITS-1:0] w4
   );
      tile_config_type cfg;
      cfg.tile_count = COUNT_BITS'(count);
      cfg.weight[0] = w0;
      cfg.weight[1] = w1;
      cfg.weight[2] = w2;
      cfg.weight[3] = w3;
      cfg.weight[4] = w4;
      return cfg;
   endfunction

   // Mostly a narrow palette so that tiles often fit their neighbours.
   function automatic logic [COLOR_BITS-1:0] palette_color();
      if ($urandom_range(0, 3) == 0) begin
         return COLOR_BITS'($urandom_range(0, 15));
      end
      return COLOR_BITS'($urandom_range(0, 3));
   endfunction

   function automatic logic [COLOR_BITS-1:0] facing_color(
      input logic [COLOR_BITS-1:0] fit, input bit noisy
   );
      if (noisy || $urandom_range(0, 3) == 0) begin
         return COLOR_BITS'($urandom_range(0, 15));
      end
      return fit;
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] random_weight();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return WEIGHT_BITS'(1);
         2: return WEIGHT_N_RESET << 24;
         3: return WEIGHT_FULL;
         default: return WEIGHT_BITS'($urandom_range(1, 1 << 24));
      endcase
   endfunction

   // Tile counts lean small; a few phases use the whole table or more.
   function automatic tile_config_type random_config();
      tile_config_type cfg;
      case ($urandom_range(0, 7))
         0: cfg.tile_count = COUNT_BITS'(TILE_SLOTS);
         1: cfg.tile_count = COUNT_BITS'($urandom_range(TILE_SLOTS + 1, 127));
         2: cfg.tile_count = COUNT_BITS'($urandom_range(0, 1));
         default: cfg.tile_count = COUNT_BITS'($urandom_range(2, 24));
      endcase
      for (int k = 0; k < WEIGHTS; k++) begin
         cfg.weight[k] = random_weight();
      end
      return cfg;
   endfunction

   // Updates mostly face colors taken from some table entry, so low energies occur.
   function automatic tile_request_type random_request();
      tile_request_type rq;
      logic [SIDES*COLOR_BITS-1:0] fit;
      bit noisy;
      int unsigned pick;
      rq.tile_index = TILE_BITS'($urandom_range(0, TILE_SLOTS - 1));
      rq.random_word = $urandom;
      rq.edge_mask = SIDES'($urandom_range(0, 15));
      pick = $urandom_range(0, 19);
      rq.lock_mode = (pick < 9) ? LOCK_FREE : (pick < 16) ? LOCK_BOUNDARY :
                     (pick < 18) ? LOCK_PINNED : LOCK_SPARE;
      if ($urandom_range(0, 6) == 0) begin
         rq.mode = MODE_LOAD;
         rq.color_top = palette_color();
         rq.color_bottom = palette_color();
         rq.color_left = palette_color();
         rq.color_right = palette_color();
      end else begin
         rq.mode = MODE_UPDATE;
         fit = tile_colors[$urandom_range(0, TILE_SLOTS - 1)];
         noisy = ($urandom_range(0, 7) == 0);
         rq.color_top = facing_color(fit[0*COLOR_BITS +: COLOR_BITS], noisy);
         rq.color_bottom = facing_color(fit[1*COLOR_BITS +: COLOR_BITS], noisy);
         rq.color_left = facing_color(fit[2*COLOR_BITS +: COLOR_BITS], noisy);
         rq.color_right = facing_color(fit[3*COLOR_BITS +: COLOR_BITS], noisy);
      end
      return rq;
   endfunction

   // Offer one request after a random gap and record what it should produce.
   task automatic send_request(input tile_request_type rq, input bit typed,
                               input tile_result_type want);
      int unsigned gap;
      if ($urandom_range(0, 31) == 0) begin
         send_quiet = !send_quiet;
      end
      gap = send_quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= rq.mode;
      req_tile_index <= rq.tile_index;
      req_color_top <= rq.color_top;
      req_color_bottom <= rq.color_bottom;
      req_color_left <= rq.color_left;
      req_color_right <= rq.color_right;
      req_edge_mask <= rq.edge_mask;
      req_lock_mode <= rq.lock_mode;
      req_random_word <= rq.random_word;
      do @(posedge clock); while (!req_ready);
      if (rq.mode == MODE_LOAD) begin
         tile_colors[rq.tile_index] = {rq.color_right, rq.color_left,
                                       rq.color_bottom, rq.color_top};
      end else begin
         expected_tiles.push_back(typed ? want : predict_update(rq));
      end
   endtask

   // Let every outstanding update return, then give a trailing load time to finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_tiles.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all six registers on consecutive edges.
   task automatic apply_config(input tile_config_type cfg);
      for (int k = 0; k <= WEIGHTS; k++) begin
         csr_write_enable <= 1'b1;
         if (k == 0) begin
            csr_index <= CSR_TILE_COUNT;
            csr_write_data <= WEIGHT_BITS'(cfg.tile_count);
         end else begin
            csr_index <= CSR_WEIGHT_0 + CSR_BITS'(k - 1);
            csr_write_data <= cfg.weight[k-1];
         end
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      live_config = cfg;
   endtask

   task automatic add_request(input tile_request_type rq, input bit typed,
                              input int unsigned tile, input bit kept);
      stimulus_row_type row;
      row = '0;
      row.rq = rq;
      row.typed = typed;
      row.want.new_tile = TILE_BITS'(tile);
      row.want.kept = kept;
      directed_rows.push_back(row);
   endtask

   task automatic add_config(input tile_config_type cfg);
      stimulus_row_type row;
      row = '0;
      row.is_config = 1'b1;
      row.cfg = cfg;
      directed_rows.push_back(row);
   endtask

   // Directed rows: corner tiles, reset settings, every lock mode, empty and
   // oversized candidate sets, zero weights and the extremes of the draw.
   task automatic build_directed();
      add_request(make_request(MODE_LOAD, 0, 0, 0, 0, 0, 0, LOCK_FREE, 0), 0, 0, 0);
      add_request(make_request(MODE_LOAD, 63, 15, 15, 15, 15, 15, LOCK_FREE, '1), 0, 0, 0);
      // With reset settings only tile 0 is a candidate and it always wins.
      add_request(make_request(MODE_UPDATE, 63, 15, 15, 15, 15, 15, LOCK_FREE, '1), 1, 0, 0);
      add_request(make_request(MODE_UPDATE, 0, 0, 0, 0, 0, 0, LOCK_FREE, 0), 1, 0, 0);
      add_request(make_request(MODE_UPDATE, 37, 3, 9, 12, 1, 10, LOCK_PINNED, '1), 1, 37, 1);
      add_request(make_request(MODE_UPDATE, 5, 1, 2, 3, 4, 15, LOCK_SPARE, 7), 1, 5, 1);
      // Tile 0 does not keep the boundary of tile 63, so nothing is allowed.
      add_request(make_request(MODE_UPDATE, 63, 0, 0, 0, 0, 0, LOCK_BOUNDARY, 9), 1, 63, 1);
      add_config(make_config(64, 25'd16777216, 25'd8388608, 25'd4194304,
                             25'd2097152, 25'd1048576));
      add_request(make_request(MODE_UPDATE, 63, 15, 15, 15, 15, 15, LOCK_FREE, 0), 0, 0, 0);
      add_request(make_request(MODE_UPDATE, 63, 15, 15, 15, 15, 15, LOCK_FREE, '1), 0, 0, 0);
      add_request(make_request(MODE_UPDATE, 63, 0, 0, 0, 0, 0, LOCK_BOUNDARY, 32'h4000_0000),
                  0, 0, 0);
      add_request(make_request(MODE_UPDATE, 10, 1, 2, 3, 0, 5, LOCK_BOUNDARY, 32'hC000_0000),
                  0, 0, 0);
      add_request(make_request(MODE_UPDATE, 20, 1, 2, 3, 0, 15, LOCK_FREE, 32'h8000_0000),
                  0, 0, 0);
      add_config(make_config(0, WEIGHT_FULL, WEIGHT_FULL, WEIGHT_FULL, WEIGHT_FULL,
                             WEIGHT_FULL));
      add_request(make_request(MODE_UPDATE, 12, 2, 2, 2, 2, 15, LOCK_FREE, '1), 1, 12, 1);
      add_config(make_config(127, 0, 0, 0, 0, 0));
      add_request(make_request(MODE_UPDATE, 40, 1, 1, 1, 1, 15, LOCK_FREE, '1), 1, 40, 1);
      add_config(make_config(127, 0, 0, 0, 0, WEIGHT_FULL));
      add_request(make_request(MODE_UPDATE, 1, 0, 0, 0, 0, 15, LOCK_FREE, '1), 0, 0, 0);
      add_request(make_request(MODE_UPDATE, 2, 5, 6, 7, 8, 15, LOCK_FREE, 32'h1234_5678),
                  0, 0, 0);
      add_config(make_config(64, 1, 1, 1, 1, 1));
      add_request(make_request(MODE_UPDATE, 30, 3, 0, 1, 2, 15, LOCK_FREE, '1), 0, 0, 0);
      add_request(make_request(MODE_UPDATE, 31, 0, 0, 0, 0, 0, LOCK_FREE, 0), 0, 0, 0);
   endtask

   // Receiver: random stalls per result and one long hold-off to back up the block.
   initial begin
      int unsigned gap;
      tile_result_type want;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 31) == 0) begin
            take_quiet = !take_quiet;
         end
         gap = take_quiet ? 0 : $urandom_range(0, 6);
         if (results_taken == HOLD_AT_RESULT) begin
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results_taken++;
         if (expected_tiles.size() == 0) begin
            $error("unexpected result: new_tile %0d, kept %0d", rsp_new_tile, rsp_kept);
            fail_count++;
         end else begin
            want = expected_tiles.pop_front();
            if (rsp_new_tile !== want.new_tile) begin
               $error("new_tile mismatch: expected %0d, actual %0d",
                      want.new_tile, rsp_new_tile);
               fail_count++;
            end
            if (rsp_kept !== want.kept) begin
               $error("kept mismatch: expected %0d, actual %0d", want.kept, rsp_kept);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // Main sequence: reset, fill the table, directed rows, random phases.
   initial begin
      stimulus_row_type row;
      tile_result_type none;
      none = '0;
      live_config = make_config(TILE_COUNT_RESET, WEIGHT_0_RESET, WEIGHT_N_RESET,
                                WEIGHT_N_RESET, WEIGHT_N_RESET, WEIGHT_N_RESET);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Every entry is written before any update can read it.
      for (int t = 0; t < TILE_SLOTS; t++) begin
         send_request(make_request(MODE_LOAD, t, palette_color(), palette_color(),
                                   palette_color(), palette_color(), 0, LOCK_FREE, 0),
                      1'b0, none);
      end

      build_directed();
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_config) begin
            wait_idle();
            apply_config(row.cfg);
         end else begin
            send_request(row.rq, row.typed, row.want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         apply_config(random_config());
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            send_request(random_request(), 1'b0, none);
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/wthb_pkg.sv
rtl/wthb_ram.sv
rtl/wthb_ctrl.sv
rtl/wthb_dp.sv
rtl/wang_tile_heat_bath_fixed.sv
tb/tb_top.sv
